// File: rtl/cmdarg_pkg.sv
// ----------------------------------------------------------------------------
// cmdarg_pkg: shared types and constants for the argument splitter
// Field width, character codes and parameter defaults used by the channel
// interfaces and the splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package cmdarg_pkg;

    localparam int FIELD_W = 16;

    typedef logic [FIELD_W-1:0] t_field;

    localparam int CHAR_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // character codes
    localparam t_field CH_TAB   = 16'h0009;
    localparam t_field CH_VTAB  = 16'h000B;
    localparam t_field CH_FF    = 16'h000C;
    localparam t_field CH_SPACE = 16'h0020;
    localparam t_field CH_DQ    = 16'h0022;
    localparam t_field CH_BSL   = 16'h005C;

endpackage

`default_nettype wire

// File: rtl/cmdarg_if.sv
// ----------------------------------------------------------------------------
// cmdarg channel interfaces
// Valid/ready channels for the character stream in and the write
// instructions out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmdarg_in_if;
    import cmdarg_pkg::*;

    logic   valid;
    logic   ready;
    t_field ch;
    logic   last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface cmdarg_out_if;
    import cmdarg_pkg::*;

    logic   valid;
    logic   ready;
    t_field backslashes;
    logic   char_valid;
    t_field out_char;
    logic   terminator;
    t_field arg_count;
    logic   done_res;

    modport source (
        output valid, output backslashes, output char_valid, output out_char,
        output terminator, output arg_count, output done_res, input ready
    );
    modport sink (
        input valid, input backslashes, input char_valid, input out_char,
        input terminator, input arg_count, input done_res, output ready
    );
endinterface

`default_nettype wire

// File: rtl/command_line_argument_splitter.sv
// ----------------------------------------------------------------------------
// command_line_argument_splitter
// Splits a command line, one character per transfer, into arguments and
// emits one write instruction per character.
// ----------------------------------------------------------------------------
// The block takes one character per clock, unless the sink holds back results,
// and returns exactly one result per character: each character passes through
// the input register and then the result register. The splitting state (quote
// flag, argument flag, pending quote, backslash run, argument count) is updated
// as a result is loaded into the result register, which sets the sustained rate
// at one character per cycle with no bubbles while the sink takes results. Each
// result tells the writer to emit 'backslashes' backslash characters, then
// out_char if char_valid, then a zero if terminator. The item marked last
// flushes any pending run, closes the argument and clears all state for the
// next line. CHAR_WIDTH selects byte (8) or 16-bit characters; COUNT_WIDTH,
// capped at the 16-bit field width, bounds the saturating argument count.
`default_nettype none

module command_line_argument_splitter #(
    parameter int CHAR_WIDTH  = cmdarg_pkg::CHAR_WIDTH_DEF,
    parameter int COUNT_WIDTH = cmdarg_pkg::COUNT_WIDTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    cmdarg_in_if.sink       i_in,
    cmdarg_out_if.source    o_out
);
    import cmdarg_pkg::*;

    localparam int TOTAL_W = (COUNT_WIDTH < FIELD_W) ? COUNT_WIDTH : FIELD_W;

    typedef logic [CHAR_WIDTH-1:0] t_char;
    typedef logic [TOTAL_W-1:0]    t_total;

    localparam t_char C_TAB   = CH_TAB[CHAR_WIDTH-1:0];
    localparam t_char C_VTAB  = CH_VTAB[CHAR_WIDTH-1:0];
    localparam t_char C_FF    = CH_FF[CHAR_WIDTH-1:0];
    localparam t_char C_SPACE = CH_SPACE[CHAR_WIDTH-1:0];
    localparam t_char C_DQ    = CH_DQ[CHAR_WIDTH-1:0];
    localparam t_char C_BSL   = CH_BSL[CHAR_WIDTH-1:0];

    // input stage
    logic   r_s1_valid;
    t_char  r_ch;
    logic   r_last;

    // splitter state
    logic   r_quoting, n_quoting;
    logic   r_inside, n_inside;
    logic   r_quote_pending, n_quote_pending;
    t_field r_slash_run, n_slash_run;
    t_total r_total, n_total;

    // result stage
    logic   r_out_valid;
    t_field r_bs;
    logic   r_cv;
    t_char  r_oc;
    logic   r_term;
    t_total r_count;
    logic   r_done;

    logic   s1_adv;
    logic   handled;
    logic   blank;
    t_field bs;
    logic   cv;
    t_char  oc;
    logic   term;
    t_total count;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    assign blank = (r_ch == C_TAB) || (r_ch == C_VTAB) || (r_ch == C_FF) ||
                   (r_ch == C_SPACE);

    always_comb begin
        n_quoting       = r_quoting;
        n_inside        = r_inside;
        n_quote_pending = r_quote_pending;
        n_slash_run     = r_slash_run;
        n_total         = r_total;
        handled         = 1'b0;
        bs              = '0;
        cv              = 1'b0;
        oc              = '0;
        term            = 1'b0;

        // resolve a pending quote or backslash run first
        if (r_quote_pending) begin
            n_quote_pending = 1'b0;
            if (r_ch == C_DQ) begin
                cv      = 1'b1;
                oc      = C_DQ;
                handled = 1'b1;
            end else begin
                n_quoting = 1'b0;
            end
        end else if (r_slash_run != '0) begin
            if (r_ch == C_BSL) begin
                if (r_slash_run != '1) begin
                    n_slash_run = r_slash_run + t_field'(1);
                end
                handled = 1'b1;
            end else begin
                if (r_ch == C_DQ) begin
                    bs = r_slash_run >> 1;
                    if (r_slash_run[0]) begin
                        cv      = 1'b1;
                        oc      = C_DQ;
                        handled = 1'b1;
                    end
                end else begin
                    bs = r_slash_run;
                end
                n_slash_run = '0;
            end
        end

        if (!handled) begin
            if (r_ch == C_BSL) begin
                if (!n_inside) begin
                    n_inside = 1'b1;
                    if (n_total != '1) n_total = n_total + t_total'(1);
                end
                n_slash_run = t_field'(1);
            end else if (r_ch == C_DQ) begin
                if (!n_quoting) begin
                    n_quoting = 1'b1;
                    if (!n_inside) begin
                        n_inside = 1'b1;
                        if (n_total != '1) n_total = n_total + t_total'(1);
                    end
                end else begin
                    n_quote_pending = 1'b1;
                end
            end else if (blank) begin
                if (n_quoting) begin
                    cv = 1'b1;
                    oc = r_ch;
                end else if (n_inside) begin
                    n_inside = 1'b0;
                    term     = 1'b1;
                end
            end else begin
                cv = 1'b1;
                oc = r_ch;
                if (!n_inside) begin
                    n_inside = 1'b1;
                    if (n_total != '1) n_total = n_total + t_total'(1);
                end
            end
        end

        count = n_total;

        // final character: flush the run, close the line, clear state
        if (r_last) begin
            bs              = bs + n_slash_run;
            term            = 1'b1;
            n_quoting       = 1'b0;
            n_inside        = 1'b0;
            n_quote_pending = 1'b0;
            n_slash_run     = '0;
            n_total         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_quoting       <= 1'b0;
            r_inside        <= 1'b0;
            r_quote_pending <= 1'b0;
            r_slash_run     <= '0;
            r_total         <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid     <= 1'b1;
                r_quoting       <= n_quoting;
                r_inside        <= n_inside;
                r_quote_pending <= n_quote_pending;
                r_slash_run     <= n_slash_run;
                r_total         <= n_total;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ch   <= i_in.ch[CHAR_WIDTH-1:0];
            r_last <= i_in.last;
        end
        if (s1_adv) begin
            r_bs    <= bs;
            r_cv    <= cv;
            r_oc    <= oc;
            r_term  <= term;
            r_count <= count;
            r_done  <= r_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.backslashes = r_bs;
    assign o_out.char_valid  = r_cv;
    assign o_out.out_char    = t_field'(r_oc);
    assign o_out.terminator  = r_term;
    assign o_out.arg_count   = t_field'(r_count);
    assign o_out.done_res    = r_done;

`ifndef SYNTHESIS
    a_done_has_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_res |-> o_out.terminator)
        else $error("final result without terminator");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_last |=> (r_slash_run == '0) && !r_quoting && !r_inside &&
                             !r_quote_pending && (r_total == '0))
        else $error("state not cleared after final character");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.char_valid |-> o_out.out_char == '0)
        else $error("out_char nonzero without char_valid");

    a_pending_quoting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quote_pending |-> r_quoting && (r_slash_run == '0))
        else $error("pending quote outside quoting or with backslash run");
`endif

endmodule

`default_nettype wire
